>>> rtl/core/rtpvp_pkg.sv
// Shared types, constants and helper functions of the RTP video packetizer.
// Depends on nothing; the other files of the block, apart from rtpvp_ram, refer to it by scoped names.
package rtpvp_pkg;

  localparam int MAX_PAYLOAD = 1200;
  localparam int STORE_DEPTH = MAX_PAYLOAD + 4;
  localparam int CW          = $clog2(STORE_DEPTH + 1);
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int RAM_DEPTH   = 1 << AW;
  localparam int INQ_DEPTH   = 2;
  localparam int INQ_AW      = $clog2(INQ_DEPTH);
  localparam int INQ_CW      = $clog2(INQ_DEPTH + 1);
  localparam int OUTQ_DEPTH  = 4;
  localparam int OQ_AW       = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW       = $clog2(OUTQ_DEPTH + 1);

  localparam logic [1:0] CODEC_H264 = 2'd0;
  localparam logic [1:0] CODEC_HEVC = 2'd1;
  localparam logic [1:0] CODEC_AV1  = 2'd2;
  localparam logic [1:0] CODEC_ALT  = 2'd3;

  localparam logic CFG_CODEC = 1'b0;
  localparam logic CFG_SSRC  = 1'b1;

  localparam logic [7:0]  RTP_VER_BYTE  = 8'h80;
  localparam logic [7:0]  RTP_PT        = 8'd96;
  localparam logic [7:0]  MARKER_BIT    = 8'h80;
  localparam logic [31:0] TS_STEP       = 32'd3000;
  localparam logic [4:0]  HDR_FIXED     = 5'd12;
  localparam logic [7:0]  FU_A_TYPE     = 8'd28;
  localparam logic [7:0]  HEVC_FU_TYPE  = 8'd49;
  localparam logic [7:0]  NRI_MASK      = 8'h60;
  localparam logic [7:0]  TYPE_MASK     = 8'h1F;
  localparam logic [7:0]  FU_START      = 8'h80;
  localparam logic [7:0]  FU_END        = 8'h40;
  localparam logic [7:0]  FU_MID        = 8'h00;
  localparam logic [7:0]  AV1_AGG_FIRST = 8'h40;
  localparam logic [7:0]  AV1_AGG_MID   = 8'hC0;
  localparam logic [7:0]  AV1_AGG_LAST  = 8'h80;
  localparam logic [7:0]  AV1_AGG_ONE   = 8'h10;
  localparam logic [7:0]  AV1_AGG_KEY   = 8'h08;

  typedef struct packed {
    logic        op;
    logic [7:0]  frame_byte;
    logic        frame_final;
    logic [31:0] frame_number;
    logic        key_frame;
  } in_word_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_data;
    logic       packet_final;
    logic       push_refused;
  } out_word_t;

  typedef enum logic {
    CMD_PUSH,
    CMD_PULL
  } cmd_kind_t;

  typedef struct packed {
    logic        valid;
    cmd_kind_t   kind;
    logic [7:0]  frame_byte;
    logic        frame_final;
    logic [31:0] frame_number;
    logic        key_frame;
  } cmd_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FIRST,
    ACT_MIDDLE,
    ACT_SCAN,
    ACT_SETTLE,
    ACT_TAIL_END
  } act_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } extra_t;

  function automatic extra_t fu_extra(input logic hevc, input logic [15:0] uh,
                                      input logic [7:0] se);
    extra_t     e;
    logic [7:0] h0;
    if (hevc) begin
      h0    = uh[15:8];
      e.len = 2'd3;
      e.b0  = {HEVC_FU_TYPE[6:0], 1'b0} | {7'b0, h0[0]};
      e.b1  = uh[7:0];
      e.b2  = {2'b0, h0[6:1]} | se;
    end else begin
      h0    = uh[7:0];
      e.len = 2'd2;
      e.b0  = (h0 & NRI_MASK) | FU_A_TYPE;
      e.b1  = (h0 & TYPE_MASK) | se;
      e.b2  = 8'h00;
    end
    return e;
  endfunction

  function automatic extra_t agg_extra(input logic [7:0] v);
    extra_t e;
    e.len = 2'd1;
    e.b0  = v;
    e.b1  = 8'h00;
    e.b2  = 8'h00;
    return e;
  endfunction

  function automatic logic [7:0] header_byte(input logic [4:0] step, input logic marker,
                                             input logic [15:0] seq, input logic [31:0] stamp,
                                             input logic [31:0] ssrc, input extra_t ex);
    logic [7:0] b;
    unique case (step)
      5'd0:    b = RTP_VER_BYTE;
      5'd1:    b = RTP_PT | (marker ? MARKER_BIT : 8'h00);
      5'd2:    b = seq[15:8];
      5'd3:    b = seq[7:0];
      5'd4:    b = stamp[31:24];
      5'd5:    b = stamp[23:16];
      5'd6:    b = stamp[15:8];
      5'd7:    b = stamp[7:0];
      5'd8:    b = ssrc[31:24];
      5'd9:    b = ssrc[23:16];
      5'd10:   b = ssrc[15:8];
      5'd11:   b = ssrc[7:0];
      5'd12:   b = ex.b0;
      5'd13:   b = ex.b1;
      5'd14:   b = ex.b2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One step of the packet-forming loop, decided from the engine state.
  function automatic act_t classify(input logic in_frame, input logic draining,
                                    input logic frag, input logic tail,
                                    input logic [1:0] codec, input logic [CW-1:0] settled,
                                    input logic [2:0] u);
    logic [CW-1:0] lim;
    logic [CW-1:0] piece;
    act_t          a;
    lim   = (codec == CODEC_AV1) ? CW'(MAX_PAYLOAD - 1) : CW'(MAX_PAYLOAD);
    piece = (codec == CODEC_HEVC) ? CW'(MAX_PAYLOAD - 3) :
            (codec == CODEC_AV1)  ? CW'(MAX_PAYLOAD - 1) : CW'(MAX_PAYLOAD - 2);
    if (!in_frame || draining)                    a = ACT_NONE;
    else if (!frag && settled > lim)              a = ACT_FIRST;
    else if (frag && settled > piece)             a = ACT_MIDDLE;
    else if (codec != CODEC_AV1 && u >= 3'd4)     a = ACT_SCAN;
    else if (codec == CODEC_AV1 && u != 3'd0)     a = ACT_SETTLE;
    else if (tail)                                a = (u != 3'd0) ? ACT_SETTLE : ACT_TAIL_END;
    else                                          a = ACT_NONE;
    return a;
  endfunction

endpackage

>>> rtl/core/rtpvp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module rtpvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/rtpvp_front.sv
// Front end: a two-word input queue that classifies each word as a push or a pull.
// Depends on rtpvp_pkg.
module rtpvp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  rtpvp_pkg::in_word_t in_word,
  output rtpvp_pkg::cmd_t     cmd,
  input  logic                cmd_pop
);

  rtpvp_pkg::in_word_t                 slot_r [rtpvp_pkg::INQ_DEPTH];
  logic [rtpvp_pkg::INQ_AW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [rtpvp_pkg::INQ_AW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [rtpvp_pkg::INQ_CW-1:0]        cnt_r, cnt_nxt;
  logic                                wr_en, rd_en;
  rtpvp_pkg::in_word_t                 head;

  assign in_full = (cnt_r == rtpvp_pkg::INQ_CW'(rtpvp_pkg::INQ_DEPTH));
  assign wr_en   = in_push && !in_full;
  assign rd_en   = cmd_pop && (cnt_r != '0);
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    cmd.valid        = (cnt_r != '0);
    cmd.kind         = head.op ? rtpvp_pkg::CMD_PULL : rtpvp_pkg::CMD_PUSH;
    cmd.frame_byte   = head.frame_byte;
    cmd.frame_final  = head.frame_final;
    cmd.frame_number = head.frame_number;
    cmd.key_frame    = head.key_frame;
  end

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + rtpvp_pkg::INQ_CW'(wr_en) - rtpvp_pkg::INQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= in_word;
    end
  end

endmodule

>>> rtl/core/rtpvp_outq.sv
// Result queue: holds finished result words until the consumer pops them.
// Depends on rtpvp_pkg.
module rtpvp_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rtpvp_pkg::res_t              res,
  output logic [rtpvp_pkg::OQ_CW-1:0]  count,
  output logic                         out_empty,
  input  logic                         out_pop,
  output rtpvp_pkg::out_word_t         out_word
);

  rtpvp_pkg::out_word_t             slot_r [rtpvp_pkg::OUTQ_DEPTH];
  logic [rtpvp_pkg::OQ_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [rtpvp_pkg::OQ_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [rtpvp_pkg::OQ_CW-1:0]      cnt_r, cnt_nxt;
  logic                             rd_en;

  // The engine only issues a word when it has reserved a free slot.
  assign out_empty = (cnt_r == '0);
  assign rd_en     = out_pop && !out_empty;
  assign out_word  = slot_r[rd_ptr_r];
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = res.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + rtpvp_pkg::OQ_CW'(res.valid) - rtpvp_pkg::OQ_CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      slot_r[wr_ptr_r] <= res.word;
    end
  end

endmodule

>>> rtl/core/rtpvp_engine.sv
// Back end: frame store, start-code scan, packet forming and header/payload drain.
// Depends on rtpvp_pkg and rtpvp_ram.
module rtpvp_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rtpvp_pkg::cmd_t              cmd,
  output logic                         cmd_pop,
  input  logic [rtpvp_pkg::OQ_CW-1:0]  oq_count,
  output rtpvp_pkg::res_t              res,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [31:0]                  cfg_data
);

  localparam int CW = rtpvp_pkg::CW;
  localparam int AW = rtpvp_pkg::AW;

  // Configuration.
  logic [1:0]  codec_sel_r;
  logic [31:0] ssrc_r;

  // Control state.
  logic          in_frame_r, in_frame_nxt;
  logic          draining_r, draining_nxt;
  logic          frag_r, frag_nxt;
  logic          tail_r, tail_nxt;
  logic          leading_r, leading_nxt;
  logic [1:0]    codec_r, codec_nxt;
  logic          key_r, key_nxt;
  logic [15:0]   seq_r, seq_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [CW-1:0] settled_r, settled_nxt;
  logic [2:0]    u_r, u_nxt;
  logic [4:0]    hstep_r, hstep_nxt;
  logic [CW-1:0] dix_r, dix_nxt;
  logic [CW-1:0] pay_r, pay_nxt;
  logic          marker_r, marker_nxt;
  logic          s2_valid_r, s2_valid_nxt;

  // Payload state.
  logic [31:0]       stamp_r, stamp_nxt;
  logic [7:0]        look_r [4];
  logic [7:0]        look_nxt [4];
  logic [7:0]        hdr0_r, hdr0_nxt;
  logic [7:0]        hdr1_r, hdr1_nxt;
  logic [15:0]       uhdr_r, uhdr_nxt;
  rtpvp_pkg::extra_t ex_r, ex_nxt;
  rtpvp_pkg::out_word_t s2_word_r, s2_word_nxt;
  logic              s2_ram_r, s2_ram_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  rtpvp_pkg::act_t   act_reg, act;
  logic              accept;
  logic [CW:0]       fill;
  logic [4:0]        head_len;
  logic              sc3, sc4;
  logic              do_start;
  logic [CW-1:0]     start_pay;
  logic              start_mark;
  rtpvp_pkg::extra_t start_ex, eu_ex;
  logic [15:0]       first_uh;

  rtpvp_ram #(
    .WIDTH(8),
    .DEPTH(rtpvp_pkg::RAM_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // An item is taken only when no loop step is pending and a result slot is free.
  assign act_reg = rtpvp_pkg::classify(in_frame_r, draining_r, frag_r, tail_r, codec_r,
                                       settled_r, u_r);
  assign accept  = cmd.valid && (act_reg == rtpvp_pkg::ACT_NONE) &&
                   ((oq_count + rtpvp_pkg::OQ_CW'(s2_valid_r)) <
                    rtpvp_pkg::OQ_CW'(rtpvp_pkg::OUTQ_DEPTH));
  assign cmd_pop = accept;

  assign fill      = (CW + 1)'(settled_r) + (CW + 1)'(u_r);
  assign head_len  = rtpvp_pkg::HDR_FIXED + 5'(ex_r.len);
  assign ram_raddr = base_r + dix_r[AW-1:0];

  always_comb begin
    in_frame_nxt = in_frame_r;
    draining_nxt = draining_r;
    frag_nxt     = frag_r;
    tail_nxt     = tail_r;
    leading_nxt  = leading_r;
    codec_nxt    = codec_r;
    key_nxt      = key_r;
    seq_nxt      = seq_r;
    base_nxt     = base_r;
    settled_nxt  = settled_r;
    u_nxt        = u_r;
    hstep_nxt    = hstep_r;
    dix_nxt      = dix_r;
    pay_nxt      = pay_r;
    marker_nxt   = marker_r;
    stamp_nxt    = stamp_r;
    for (int i = 0; i < 4; i++) look_nxt[i] = look_r[i];
    hdr0_nxt     = hdr0_r;
    hdr1_nxt     = hdr1_r;
    uhdr_nxt     = uhdr_r;
    ex_nxt       = ex_r;
    s2_valid_nxt = accept;
    s2_word_nxt  = '0;
    s2_ram_nxt   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;

    // First apply the accepted word itself.
    if (accept) begin
      if (cmd.kind == rtpvp_pkg::CMD_PUSH) begin
        if (draining_r || fill >= (CW + 1)'(rtpvp_pkg::STORE_DEPTH)) begin
          s2_word_nxt.push_refused = 1'b1;
        end else begin
          if (!in_frame_r) begin
            in_frame_nxt = 1'b1;
            leading_nxt  = 1'b1;
            tail_nxt     = 1'b0;
            frag_nxt     = 1'b0;
            codec_nxt    = (codec_sel_r == rtpvp_pkg::CODEC_ALT) ? rtpvp_pkg::CODEC_H264 :
                           codec_sel_r;
            stamp_nxt    = cmd.frame_number * rtpvp_pkg::TS_STEP;
            key_nxt      = cmd.key_frame;
          end
          look_nxt[u_r[1:0]] = cmd.frame_byte;
          u_nxt = u_r + 3'd1;
          if (cmd.frame_final) tail_nxt = 1'b1;
        end
      end else if (draining_r) begin
        s2_word_nxt.byte_valid = 1'b1;
        if (hstep_r < head_len) begin
          s2_word_nxt.out_data = rtpvp_pkg::header_byte(hstep_r, marker_r, seq_r, stamp_r,
                                                        ssrc_r, ex_r);
          hstep_nxt = hstep_r + 5'd1;
        end else begin
          s2_ram_nxt = 1'b1;
          dix_nxt    = dix_r + CW'(1);
        end
        if (hstep_nxt >= head_len && dix_nxt >= pay_r) begin
          s2_word_nxt.packet_final = 1'b1;
          seq_nxt      = seq_r + 16'd1;
          draining_nxt = 1'b0;
          base_nxt     = base_r + pay_r[AW-1:0];
          settled_nxt  = (settled_r >= pay_r) ? settled_r - pay_r : '0;
        end
      end
    end

    // Then one step of the packet-forming loop on the updated state.
    act = rtpvp_pkg::classify(in_frame_nxt, draining_nxt, frag_nxt, tail_nxt, codec_nxt,
                              settled_nxt, u_nxt);
    sc3 = (look_nxt[0] == 8'h00) && (look_nxt[1] == 8'h00) && (look_nxt[2] == 8'h01);
    sc4 = (look_nxt[0] == 8'h00) && (look_nxt[1] == 8'h00) && (look_nxt[2] == 8'h00) &&
          (look_nxt[3] == 8'h01);

    if (frag_nxt) begin
      eu_ex = (codec_nxt == rtpvp_pkg::CODEC_AV1) ?
              rtpvp_pkg::agg_extra(rtpvp_pkg::AV1_AGG_LAST) :
              rtpvp_pkg::fu_extra(codec_nxt == rtpvp_pkg::CODEC_HEVC, uhdr_r,
                                  rtpvp_pkg::FU_END);
    end else if (codec_nxt == rtpvp_pkg::CODEC_AV1) begin
      eu_ex = rtpvp_pkg::agg_extra(rtpvp_pkg::AV1_AGG_ONE |
                                   (key_nxt ? rtpvp_pkg::AV1_AGG_KEY : 8'h00));
    end else begin
      eu_ex = '0;
    end
    first_uh = (codec_nxt == rtpvp_pkg::CODEC_HEVC) ? {hdr0_r, hdr1_r} :
               (codec_nxt == rtpvp_pkg::CODEC_AV1)  ? uhdr_r : {8'h00, hdr0_r};

    do_start   = 1'b0;
    start_pay  = settled_nxt;
    start_mark = 1'b0;
    start_ex   = eu_ex;

    case (act)
      rtpvp_pkg::ACT_FIRST: begin
        uhdr_nxt = first_uh;
        if (codec_nxt == rtpvp_pkg::CODEC_HEVC) begin
          base_nxt    = base_nxt + AW'(2);
          settled_nxt = settled_nxt - CW'(2);
        end else if (codec_nxt != rtpvp_pkg::CODEC_AV1) begin
          base_nxt    = base_nxt + AW'(1);
          settled_nxt = settled_nxt - CW'(1);
        end
        start_ex = (codec_nxt == rtpvp_pkg::CODEC_AV1) ?
                   rtpvp_pkg::agg_extra(rtpvp_pkg::AV1_AGG_FIRST |
                                        (key_nxt ? rtpvp_pkg::AV1_AGG_KEY : 8'h00)) :
                   rtpvp_pkg::fu_extra(codec_nxt == rtpvp_pkg::CODEC_HEVC, first_uh,
                                       rtpvp_pkg::FU_START);
        frag_nxt  = 1'b1;
        do_start  = 1'b1;
        start_pay = (codec_nxt == rtpvp_pkg::CODEC_HEVC) ? CW'(rtpvp_pkg::MAX_PAYLOAD - 3) :
                    (codec_nxt == rtpvp_pkg::CODEC_AV1)  ? CW'(rtpvp_pkg::MAX_PAYLOAD - 1) :
                                                           CW'(rtpvp_pkg::MAX_PAYLOAD - 2);
      end
      rtpvp_pkg::ACT_MIDDLE: begin
        start_ex = (codec_nxt == rtpvp_pkg::CODEC_AV1) ?
                   rtpvp_pkg::agg_extra(rtpvp_pkg::AV1_AGG_MID) :
                   rtpvp_pkg::fu_extra(codec_nxt == rtpvp_pkg::CODEC_HEVC, uhdr_r,
                                       rtpvp_pkg::FU_MID);
        do_start  = 1'b1;
        start_pay = (codec_nxt == rtpvp_pkg::CODEC_HEVC) ? CW'(rtpvp_pkg::MAX_PAYLOAD - 3) :
                    (codec_nxt == rtpvp_pkg::CODEC_AV1)  ? CW'(rtpvp_pkg::MAX_PAYLOAD - 1) :
                                                           CW'(rtpvp_pkg::MAX_PAYLOAD - 2);
      end
      rtpvp_pkg::ACT_SCAN: begin
        if (sc3 || sc4) begin
          // Strip the start code; the first one of a frame forms no packet.
          if (sc3) begin
            look_nxt[0] = look_nxt[3];
            u_nxt       = u_nxt - 3'd3;
          end else begin
            u_nxt       = 3'd0;
          end
          if (leading_nxt) begin
            leading_nxt = 1'b0;
          end else begin
            frag_nxt = 1'b0;
            do_start = 1'b1;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = base_nxt + settled_nxt[AW-1:0];
          ram_wdata = look_nxt[0];
          if (settled_nxt == CW'(0)) hdr0_nxt = look_nxt[0];
          if (settled_nxt == CW'(1)) hdr1_nxt = look_nxt[0];
          look_nxt[0] = look_nxt[1];
          look_nxt[1] = look_nxt[2];
          look_nxt[2] = look_nxt[3];
          u_nxt       = u_nxt - 3'd1;
          settled_nxt = settled_nxt + CW'(1);
          leading_nxt = 1'b0;
        end
      end
      rtpvp_pkg::ACT_SETTLE: begin
        ram_we    = 1'b1;
        ram_waddr = base_nxt + settled_nxt[AW-1:0];
        ram_wdata = look_nxt[0];
        if (settled_nxt == CW'(0)) hdr0_nxt = look_nxt[0];
        if (settled_nxt == CW'(1)) hdr1_nxt = look_nxt[0];
        look_nxt[0] = look_nxt[1];
        look_nxt[1] = look_nxt[2];
        look_nxt[2] = look_nxt[3];
        u_nxt       = u_nxt - 3'd1;
        settled_nxt = settled_nxt + CW'(1);
        leading_nxt = 1'b0;
      end
      rtpvp_pkg::ACT_TAIL_END: begin
        frag_nxt     = 1'b0;
        do_start     = 1'b1;
        start_mark   = 1'b1;
        in_frame_nxt = 1'b0;
        tail_nxt     = 1'b0;
      end
      default: begin
      end
    endcase

    if (do_start) begin
      pay_nxt      = start_pay;
      marker_nxt   = start_mark;
      ex_nxt       = start_ex;
      hstep_nxt    = '0;
      dix_nxt      = '0;
      draining_nxt = 1'b1;
    end
  end

  always_comb begin
    res.valid             = s2_valid_r;
    res.word              = s2_word_r;
    res.word.out_data     = s2_ram_r ? ram_rdata : s2_word_r.out_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_sel_r <= rtpvp_pkg::CODEC_H264;
      ssrc_r      <= '0;
      in_frame_r  <= 1'b0;
      draining_r  <= 1'b0;
      frag_r      <= 1'b0;
      tail_r      <= 1'b0;
      leading_r   <= 1'b0;
      codec_r     <= rtpvp_pkg::CODEC_H264;
      key_r       <= 1'b0;
      seq_r       <= '0;
      base_r      <= '0;
      settled_r   <= '0;
      u_r         <= '0;
      hstep_r     <= '0;
      dix_r       <= '0;
      pay_r       <= '0;
      marker_r    <= 1'b0;
      s2_valid_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == rtpvp_pkg::CFG_CODEC) codec_sel_r <= cfg_data[1:0];
      if (cfg_we && cfg_index == rtpvp_pkg::CFG_SSRC)  ssrc_r      <= cfg_data;
      in_frame_r  <= in_frame_nxt;
      draining_r  <= draining_nxt;
      frag_r      <= frag_nxt;
      tail_r      <= tail_nxt;
      leading_r   <= leading_nxt;
      codec_r     <= codec_nxt;
      key_r       <= key_nxt;
      seq_r       <= seq_nxt;
      base_r      <= base_nxt;
      settled_r   <= settled_nxt;
      u_r         <= u_nxt;
      hstep_r     <= hstep_nxt;
      dix_r       <= dix_nxt;
      pay_r       <= pay_nxt;
      marker_r    <= marker_nxt;
      s2_valid_r  <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r   <= stamp_nxt;
    for (int i = 0; i < 4; i++) look_r[i] <= look_nxt[i];
    hdr0_r    <= hdr0_nxt;
    hdr1_r    <= hdr1_nxt;
    uhdr_r    <= uhdr_nxt;
    ex_r      <= ex_nxt;
    s2_word_r <= s2_word_nxt;
    s2_ram_r  <= s2_ram_nxt;
  end

endmodule

>>> rtl/core/rtp_video_packetizer_core.sv
// Top level of the RTP video packetizer: input queue, packet engine and result queue.
// Depends on rtpvp_pkg, rtpvp_front, rtpvp_engine and rtpvp_outq.
//
//   Channel   Handshake            Word
//   in        in_push / in_full    in_word : op, frame_byte, frame_final, frame_number, key_frame
//   out       out_pop / out_empty  out_word: byte_valid, out_data, packet_final, push_refused
//   cfg       cfg_we               cfg_index selects codec_select (0) or stream_source_id (1)
//
// Every input word yields exactly one result word. The engine can take a new word before the
// last one's result has left it, so words stream back to back while no loop step is pending
// and a result slot is free. The engine runs the packet-forming loop one step per cycle while
// no packet is draining: the first step rides along with the word, and each further step (a
// byte stored, a start code stripped, a fragment cut, the end of a frame) holds back the next
// word. A result passes a stage register before it reaches the result queue, because payload
// bytes come from the registered read port of the frame store. Reset is synchronous and
// clears all control state; the frame store needs no clearing pass, as only bytes already
// written are ever read back. When the result queue fills up the engine stops taking words, and
// the input queue then raises in_full; either side may stall at any time without losing a word.
module rtp_video_packetizer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  rtpvp_pkg::in_word_t  in_word,
  output logic                 out_empty,
  input  logic                 out_pop,
  output rtpvp_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  rtpvp_pkg::cmd_t                cmd;
  logic                           cmd_pop;
  rtpvp_pkg::res_t                res;
  logic [rtpvp_pkg::OQ_CW-1:0]    oq_count;

  // The front queue decouples the producer from loop steps inside the engine.
  rtpvp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_word(in_word),
    .cmd    (cmd),
    .cmd_pop(cmd_pop)
  );

  // The engine reserves a result slot for each word it takes, counting the one in flight.
  rtpvp_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .oq_count (oq_count),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // The result queue lets the consumer stall while the engine keeps working.
  rtpvp_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .count    (oq_count),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_word (out_word)
  );

endmodule

>>> rtl/core/rtpvp_checker.sv
// Port-level checks of the RTP video packetizer, bound to the top level.
// Depends on rtpvp_pkg and rtp_video_packetizer_core.
module rtpvp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_push,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input rtpvp_pkg::out_word_t out_word
);

  // Coming out of reset both queues are empty.
  a_reset_out_empty: assert property (@(posedge clk) $rose(rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  a_reset_in_free: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full right after reset");

  // A waiting word stays put until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting result changed or vanished");

  // A packet ends only on a delivered byte, and a refusal carries no byte.
  a_final_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_word.packet_final || out_word.push_refused)) |->
    (out_word.byte_valid != out_word.push_refused))
    else $error("packet end without byte, or refusal with byte");

endmodule

bind rtp_video_packetizer_core rtpvp_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_push  (in_push),
  .in_full  (in_full),
  .out_empty(out_empty),
  .out_pop  (out_pop),
  .out_word (out_word)
);
